FILE: rtl/cfr_pkg.sv
// Shared constants and types for the clock frame replacement unit.
// No dependencies; used by the top level and the entry RAM hookup.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam int FRAMES  = 64;
    localparam int IDX_W   = $clog2(FRAMES);
    localparam int FUNC_W  = 2;
    localparam int FRAME_W = 6;
    localparam int OWNER_W = 8;
    localparam int PAGE_W  = 20;
    localparam int ENTRY_W = OWNER_W + PAGE_W;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TOUCH = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SWEEP = 5'b00100,
        ST_READ  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/clock_frame_replacement_unit.sv
// Clock frame replacement unit: frame table with second-chance eviction.
// Depends on cfr_pkg and cfr_ram (owner/page entry store).
// Free and touch go straight to the result stage. Allocate with a free frame:
// takes f, the lowest free frame index (one frame checked a cycle).
// Allocate with eviction: a full scan, then s = hand steps (1..FRAMES+1);
// the hand walks one frame a cycle. One item at a time.
// Reset: all frames free, accessed bits clear, hand on the last frame.
`timescale 1ns / 1ps
`default_nettype none

module clock_frame_replacement_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [cfr_pkg::FUNC_W-1:0]    func,
    input  wire logic [cfr_pkg::FRAME_W-1:0]   frame_index,
    input  wire logic [cfr_pkg::OWNER_W-1:0]   owner_id,
    input  wire logic [cfr_pkg::PAGE_W-1:0]    virtual_page,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic                               status,
    output logic      [cfr_pkg::FRAME_W-1:0]   granted_frame,
    output logic                               evicted,
    output logic      [cfr_pkg::OWNER_W-1:0]   victim_owner,
    output logic      [cfr_pkg::PAGE_W-1:0]    victim_page
);

    localparam logic [cfr_pkg::IDX_W-1:0] LAST_IDX = cfr_pkg::IDX_W'(cfr_pkg::FRAMES - 1);

    cfr_pkg::state_t state_reg, state_next;

    logic [cfr_pkg::FRAMES-1:0] in_use_reg, in_use_next;
    logic [cfr_pkg::FRAMES-1:0] acc_reg, acc_next;
    logic [cfr_pkg::IDX_W-1:0]  hand_reg, hand_next;
    logic [cfr_pkg::IDX_W-1:0]  scan_reg, scan_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    // item payload and staged result
    logic [cfr_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic [cfr_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic                        res_status_reg, res_status_next;
    logic [cfr_pkg::FRAME_W-1:0] res_granted_reg, res_granted_next;
    logic                        res_evicted_reg, res_evicted_next;
    logic [cfr_pkg::OWNER_W-1:0] res_vown_reg, res_vown_next;
    logic [cfr_pkg::PAGE_W-1:0]  res_vpage_reg, res_vpage_next;

    // output register
    logic                        out_status_reg, out_status_next;
    logic [cfr_pkg::FRAME_W-1:0] out_granted_reg, out_granted_next;
    logic                        out_evicted_reg, out_evicted_next;
    logic [cfr_pkg::OWNER_W-1:0] out_vown_reg, out_vown_next;
    logic [cfr_pkg::PAGE_W-1:0]  out_vpage_reg, out_vpage_next;

    logic [cfr_pkg::IDX_W-1:0]   hand_adv;
    logic [cfr_pkg::IDX_W-1:0]   req_idx;
    logic                        req_idx_ok;

    logic                        ram_we;
    logic [cfr_pkg::IDX_W-1:0]   ram_waddr;
    logic [cfr_pkg::ENTRY_W-1:0] ram_wdata;
    logic [cfr_pkg::ENTRY_W-1:0] ram_rdata;

    assign hand_adv   = (hand_reg == LAST_IDX) ? '0 : hand_reg + 1'b1;
    assign req_idx    = cfr_pkg::IDX_W'(frame_index);
    assign req_idx_ok = 32'(frame_index) < 32'(cfr_pkg::FRAMES);

    assign req_stall = (state_reg != cfr_pkg::ST_IDLE);

    cfr_ram #(
        .WIDTH (cfr_pkg::ENTRY_W),
        .DEPTH (cfr_pkg::FRAMES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (hand_adv),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        in_use_next      = in_use_reg;
        acc_next         = acc_reg;
        hand_next        = hand_reg;
        scan_next        = scan_reg;
        rsp_valid_next   = rsp_valid_reg;
        owner_next       = owner_reg;
        page_next        = page_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_evicted_next = res_evicted_reg;
        res_vown_next    = res_vown_reg;
        res_vpage_next   = res_vpage_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_evicted_next = out_evicted_reg;
        out_vown_next    = out_vown_reg;
        out_vpage_next   = out_vpage_reg;
        ram_we           = 1'b0;
        ram_waddr        = hand_reg;
        ram_wdata        = {owner_reg, page_reg};

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            cfr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    owner_next       = owner_id;
                    page_next        = virtual_page;
                    res_status_next  = 1'b0;
                    res_granted_next = frame_index;
                    res_evicted_next = 1'b0;
                    res_vown_next    = '0;
                    res_vpage_next   = '0;
                    state_next       = cfr_pkg::ST_DONE;
                    unique case (func)
                        cfr_pkg::FN_ALLOC:
                        begin
                            scan_next  = '0;
                            state_next = cfr_pkg::ST_SCAN;
                        end
                        cfr_pkg::FN_FREE:
                        begin
                            if (req_idx_ok && in_use_reg[req_idx])
                            begin
                                in_use_next[req_idx] = 1'b0;
                                acc_next[req_idx]    = 1'b0;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        cfr_pkg::FN_TOUCH:
                        begin
                            if (req_idx_ok && in_use_reg[req_idx])
                            begin
                                acc_next[req_idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                            // undefined function: no operation
                        end
                    endcase
                end
            end
            cfr_pkg::ST_SCAN:
            begin
                if (!in_use_reg[scan_reg])
                begin
                    in_use_next[scan_reg] = 1'b1;
                    acc_next[scan_reg]    = 1'b0;
                    ram_we                = 1'b1;
                    ram_waddr             = scan_reg;
                    res_granted_next      = cfr_pkg::FRAME_W'(scan_reg);
                    state_next            = cfr_pkg::ST_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = cfr_pkg::ST_SWEEP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            cfr_pkg::ST_SWEEP:
            begin
                // every frame is in use here; entry at hand_adv is read this cycle
                hand_next = hand_adv;
                if (in_use_reg[hand_adv] && acc_reg[hand_adv])
                begin
                    acc_next[hand_adv] = 1'b0;
                end
                else
                begin
                    state_next = cfr_pkg::ST_READ;
                end
            end
            cfr_pkg::ST_READ:
            begin
                res_evicted_next    = 1'b1;
                res_vown_next       = ram_rdata[cfr_pkg::ENTRY_W-1:cfr_pkg::PAGE_W];
                res_vpage_next      = ram_rdata[cfr_pkg::PAGE_W-1:0];
                res_granted_next    = cfr_pkg::FRAME_W'(hand_reg);
                in_use_next[hand_reg] = 1'b1;
                acc_next[hand_reg]  = 1'b0;
                ram_we              = 1'b1;
                ram_waddr           = hand_reg;
                state_next          = cfr_pkg::ST_DONE;
            end
            cfr_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    out_evicted_next = res_evicted_reg;
                    out_vown_next    = res_vown_reg;
                    out_vpage_next   = res_vpage_reg;
                    rsp_valid_next   = 1'b1;
                    state_next       = cfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfr_pkg::ST_IDLE;
            in_use_reg    <= '0;
            acc_reg       <= '0;
            hand_reg      <= LAST_IDX;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            acc_reg       <= acc_next;
            hand_reg      <= hand_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg       <= owner_next;
        page_reg        <= page_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_evicted_reg <= res_evicted_next;
        res_vown_reg    <= res_vown_next;
        res_vpage_reg   <= res_vpage_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_evicted_reg <= out_evicted_next;
        out_vown_reg    <= out_vown_next;
        out_vpage_reg   <= out_vpage_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = out_status_reg;
    assign granted_frame = out_granted_reg;
    assign evicted       = out_evicted_reg;
    assign victim_owner  = out_vown_reg;
    assign victim_page   = out_vpage_reg;

endmodule

`default_nettype wire

FILE: rtl/cfr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for clock_frame_replacement_unit: directed table, then random phases.
// Holds its own frame table and clock hand to predict each result; needs cfr_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import cfr_pkg::*;

    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;   // undefined code, acts as a no-op
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int TAIL_CYCLES  = 2 * FRAMES + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_ROWS     = 23;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] granted;
        logic               evicted;
        logic [OWNER_W-1:0] vown;
        logic [PAGE_W-1:0]  vpage;
    } frame_rsp_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  fn;
        logic [FRAME_W-1:0] idx;
        logic [OWNER_W-1:0] own;
        logic [PAGE_W-1:0]  page;
        logic [7:0]         reps;
        logic               typed;
        logic               exp_status;
        logic [FRAME_W-1:0] exp_granted;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [FUNC_W-1:0]  func = FN_NOP;
    logic [FRAME_W-1:0] frame_index = '0;
    logic [OWNER_W-1:0] owner_id = '0;
    logic [PAGE_W-1:0]  virtual_page = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic               status;
    logic [FRAME_W-1:0] granted_frame;
    logic               evicted;
    logic [OWNER_W-1:0] victim_owner;
    logic [PAGE_W-1:0]  victim_page;

    // typed expectation travels with the item it belongs to
    logic       row_typed = 1'b0;
    frame_rsp_t row_rsp = '0;

    // predicted frame table
    logic               in_use    [FRAMES];
    logic               acc_bit   [FRAMES];
    logic [OWNER_W-1:0] owner_tbl [FRAMES];
    logic [PAGE_W-1:0]  vpage_tbl [FRAMES];
    int                 hand;

    frame_rsp_t owed_rsps[$];
    stim_row_t  opening_rows [NUM_ROWS];
    int         errors = 0;
    int         cycles = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;

    clock_frame_replacement_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .frame_index   (frame_index),
        .owner_id      (owner_id),
        .virtual_page  (virtual_page),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_frame (granted_frame),
        .evicted       (evicted),
        .victim_owner  (victim_owner),
        .victim_page   (victim_page)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("clock_frame_replacement_unit test failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t mk_row(input logic [FUNC_W-1:0] fn, input logic [FRAME_W-1:0] idx,
                                         input logic [OWNER_W-1:0] own,
                                         input logic [PAGE_W-1:0] page, input logic [7:0] reps,
                                         input logic typed, input logic st,
                                         input logic [FRAME_W-1:0] g);
        stim_row_t row;
        row = {fn, idx, own, page, reps, typed, st, g};
        return row;
    endfunction

    // Updates the predicted table and returns the result the item should produce.
    function automatic frame_rsp_t predict_frame_op(input logic [FUNC_W-1:0] fn,
                                                    input logic [FRAME_W-1:0] idx,
                                                    input logic [OWNER_W-1:0] own,
                                                    input logic [PAGE_W-1:0] page);
        frame_rsp_t r;
        int         f;
        bit         found;
        r = '0;
        r.granted = idx;
        if (fn == FN_ALLOC)
        begin
            f = 0;
            found = 1'b0;
            while (!found && f < FRAMES)
            begin
                if (!in_use[f])
                    found = 1'b1;
                else
                    f++;
            end
            if (!found)
            begin
                // second chance: start after the hand, stop on the first clear bit
                f = hand;
                while (!found)
                begin
                    f = (f == FRAMES - 1) ? 0 : f + 1;
                    if (in_use[f] && acc_bit[f])
                        acc_bit[f] = 1'b0;
                    else
                        found = 1'b1;
                end
                hand = f;
                r.evicted = 1'b1;
                r.vown = owner_tbl[f];
                r.vpage = vpage_tbl[f];
            end
            in_use[f] = 1'b1;
            acc_bit[f] = 1'b0;
            owner_tbl[f] = own;
            vpage_tbl[f] = page;
            r.granted = f[FRAME_W-1:0];
        end
        else if (fn == FN_FREE)
        begin
            if (idx < FRAMES && in_use[idx])
            begin
                in_use[idx] = 1'b0;
                acc_bit[idx] = 1'b0;
                owner_tbl[idx] = '0;
                vpage_tbl[idx] = '0;
            end
            else
                r.status = 1'b1;
        end
        else if (fn == FN_TOUCH)
        begin
            if (idx < FRAMES && in_use[idx])
                acc_bit[idx] = 1'b1;
        end
        return r;
    endfunction

    task automatic flag_rsp_error(input string field, input logic [31:0] seen,
                                  input logic [31:0] wanted);
        if (errors < MAX_PRINTS)
            $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, seen, wanted);
        errors++;
    endtask

    always @(posedge clk)
    begin : watch
        frame_rsp_t got;
        frame_rsp_t want;
        frame_rsp_t model_rsp;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = {status, granted_frame, evicted, victim_owner, victim_page};
                if (owed_rsps.size() == 0)
                    flag_rsp_error("unexpected result, granted_frame", 32'(got.granted), 32'd0);
                else
                begin
                    want = owed_rsps.pop_front();
                    if (got.status !== want.status)
                        flag_rsp_error("status", 32'(got.status), 32'(want.status));
                    if (got.granted !== want.granted)
                        flag_rsp_error("granted_frame", 32'(got.granted), 32'(want.granted));
                    if (got.evicted !== want.evicted)
                        flag_rsp_error("evicted", 32'(got.evicted), 32'(want.evicted));
                    if (got.vown !== want.vown)
                        flag_rsp_error("victim_owner", 32'(got.vown), 32'(want.vown));
                    if (got.vpage !== want.vpage)
                        flag_rsp_error("victim_page", 32'(got.vpage), 32'(want.vpage));
                end
            end
            if (req_valid && !req_stall)
            begin
                model_rsp = predict_frame_op(func, frame_index, owner_id, virtual_page);
                owed_rsps.push_back(row_typed ? row_rsp : model_rsp);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [FRAME_W-1:0] idx,
                             input logic [OWNER_W-1:0] own, input logic [PAGE_W-1:0] page,
                             input logic typed, input frame_rsp_t rsp);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        func <= fn;
        frame_index <= idx;
        owner_id <= own;
        virtual_page <= page;
        row_typed <= typed;
        row_rsp <= rsp;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         i;
        int         ph;
        int         n;
        int         pick;
        int         w_alloc;
        int         w_free;
        logic [7:0] r;
        logic [FUNC_W-1:0] fn;
        stim_row_t  row;

        for (i = 0; i < FRAMES; i++)
        begin
            in_use[i] = 1'b0;
            acc_bit[i] = 1'b0;
            owner_tbl[i] = '0;
            vpage_tbl[i] = '0;
        end
        hand = FRAMES - 1;

        // fn, idx, owner, page, repeats, typed, status, granted
        opening_rows[0]  = mk_row(FN_TOUCH, 6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd0);
        opening_rows[1]  = mk_row(FN_FREE,  6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b1, 6'd0);
        opening_rows[2]  = mk_row(FN_FREE,  6'd63, 8'h00, 20'h00000, 8'd1,  1'b1, 1'b1, 6'd63);
        opening_rows[3]  = mk_row(FN_NOP,   6'd42, 8'hFF, 20'hFFFFF, 8'd1,  1'b1, 1'b0, 6'd42);
        opening_rows[4]  = mk_row(FN_ALLOC, 6'd63, 8'hFF, 20'hFFFFF, 8'd1,  1'b1, 1'b0, 6'd0);
        opening_rows[5]  = mk_row(FN_ALLOC, 6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd1);
        opening_rows[6]  = mk_row(FN_FREE,  6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd0);
        opening_rows[7]  = mk_row(FN_FREE,  6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b1, 6'd0);
        opening_rows[8]  = mk_row(FN_TOUCH, 6'd1,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd1);
        opening_rows[9]  = mk_row(FN_ALLOC, 6'd17, 8'h5A, 20'h12345, 8'd1,  1'b1, 1'b0, 6'd0);
        // fill the rest of the table, then sweep past touched frames
        opening_rows[10] = mk_row(FN_ALLOC, 6'd0,  8'hA0, 20'h80000, 8'd62, 1'b0, 1'b0, 6'd0);
        opening_rows[11] = mk_row(FN_TOUCH, 6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd0);
        opening_rows[12] = mk_row(FN_ALLOC, 6'd0,  8'h33, 20'h0F0F0, 8'd1,  1'b0, 1'b0, 6'd0);
        opening_rows[13] = mk_row(FN_ALLOC, 6'd0,  8'hC3, 20'hF0F0F, 8'd1,  1'b0, 1'b0, 6'd0);
        // every frame touched: the hand wraps all the way round once
        opening_rows[14] = mk_row(FN_TOUCH, 6'd0,  8'h00, 20'h00000, 8'd64, 1'b0, 1'b0, 6'd0);
        opening_rows[15] = mk_row(FN_ALLOC, 6'd0,  8'h81, 20'h7FFFF, 8'd1,  1'b0, 1'b0, 6'd0);
        opening_rows[16] = mk_row(FN_FREE,  6'd63, 8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd63);
        opening_rows[17] = mk_row(FN_ALLOC, 6'd0,  8'h00, 20'hFFFFF, 8'd1,  1'b1, 1'b0, 6'd63);
        opening_rows[18] = mk_row(FN_FREE,  6'd63, 8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd63);
        opening_rows[19] = mk_row(FN_TOUCH, 6'd63, 8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd63);
        opening_rows[20] = mk_row(FN_FREE,  6'd63, 8'h00, 20'h00000, 8'd1,  1'b1, 1'b1, 6'd63);
        opening_rows[21] = mk_row(FN_NOP,   6'd0,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd0);
        opening_rows[22] = mk_row(FN_ALLOC, 6'd9,  8'h00, 20'h00000, 8'd1,  1'b1, 1'b0, 6'd63);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
        begin
            row = opening_rows[i];
            for (r = 0; r < row.reps; r++)
                send_item(row.fn, row.idx + r[FRAME_W-1:0], row.own + r,
                          row.page + PAGE_W'(r), row.typed,
                          {row.exp_status, row.exp_granted, 1'b0, 8'd0, 20'd0});
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            quiet = (ph == 2);
            case (ph % 3)
                0:
                begin
                    w_alloc = 45;
                    w_free = 10;
                end
                1:
                begin
                    w_alloc = 40;
                    w_free = 35;
                end
                default:
                begin
                    // touch-heavy: long sweeps
                    w_alloc = 30;
                    w_free = 5;
                end
            endcase
            if (ph == 5)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < w_alloc)
                    fn = FN_ALLOC;
                else if (pick < w_alloc + w_free)
                    fn = FN_FREE;
                else if (pick < 96)
                    fn = FN_TOUCH;
                else
                    fn = FN_NOP;
                send_item(fn, FRAME_W'($urandom_range(0, FRAMES - 1)),
                          OWNER_W'($urandom_range(0, 255)),
                          PAGE_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
            end
            if (ph == 3 || ph == 7)
            begin
                // drop valid so the last item is not taken again while draining
                @(negedge clk);
                req_valid <= 1'b0;
                while (owed_rsps.size() != 0)
                    @(negedge clk);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_rsps.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("clock_frame_replacement_unit test passed");
        else
            $display("clock_frame_replacement_unit test failed");
        $finish;
    end

endmodule
